// ===== rtl/ghc_pkg.sv =====
`default_nettype none
package ghc_pkg;

  localparam int KEY_W   = 64;
  localparam int SCORE_W = 32;
  localparam int TAG_W   = 32;
  localparam int CNT_W   = 32;
  localparam int USE_W   = 13;

  typedef enum logic [1:0] {
    OP_PROBE = 2'd0,
    OP_STORE = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic               side;
    logic [SCORE_W-1:0] score;
    logic [TAG_W-1:0]   tag;
  } entry_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic sweep_wr;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic wrap;
    logic sweep_last;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/ghc_ram.sv =====
`default_nettype none
module ghc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ghc_ctrl.sv =====
`default_nettype none
module ghc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire ghc_pkg::sts_t sts,
  output ghc_pkg::cmd_t      cmd
);
  import ghc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_EXEC  = 3'b010,
    ST_SWEEP = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd          = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = sts.wrap ? ST_SWEEP : ST_IDLE;
        end
      end
      ST_SWEEP: begin
        cmd.sweep_wr = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_SWEEP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SWEEP;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ghc_dp.sv =====
`default_nettype none
module ghc_dp #(
  parameter int SLOTS = 4096,
  parameter int AW    = 12
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire ghc_pkg::cmd_t                      cmd,
  output ghc_pkg::sts_t                           sts,
  input  wire logic [1:0]                         in_op,
  input  wire logic [ghc_pkg::KEY_W-1:0]          in_key,
  input  wire logic                               in_side_to_move,
  input  wire logic signed [ghc_pkg::SCORE_W-1:0] in_store_score,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    out_hit,
  output logic signed [ghc_pkg::SCORE_W-1:0]      out_probe_score,
  output logic [ghc_pkg::USE_W-1:0]               out_entries_in_use,
  output logic [ghc_pkg::CNT_W-1:0]               out_hit_count,
  output logic [ghc_pkg::CNT_W-1:0]               out_miss_count
);
  import ghc_pkg::*;

  localparam logic [AW-1:0] IDX_MASK = AW'(SLOTS - 1);

  logic [1:0]         op_r;
  logic [KEY_W-1:0]   key_r;
  logic               side_r;
  logic [SCORE_W-1:0] score_r;
  logic [AW-1:0]      idx_r;
  logic [AW-1:0]      sweep_cnt_r, sweep_cnt_nxt;
  logic [TAG_W-1:0]   tag_r, tag_nxt;
  logic [USE_W-1:0]   use_r, use_nxt;
  logic [CNT_W-1:0]   hits_r, hits_nxt;
  logic [CNT_W-1:0]   miss_r, miss_nxt;
  logic               out_valid_r;
  logic               found_r;
  logic [SCORE_W-1:0] pscore_r;

  logic [AW-1:0]      rd_idx;
  entry_t             rd_entry, wr_entry;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic               is_probe, is_store, is_clear;
  logic               tag_match, hit;

  assign rd_idx = in_key[AW-1:0] & IDX_MASK;

  assign is_probe = (op_r == OP_PROBE);
  assign is_store = (op_r == OP_STORE);
  assign is_clear = (op_r == OP_CLEAR);

  assign tag_match = (rd_entry.tag == tag_r);
  assign hit = is_probe && tag_match && (rd_entry.key == key_r) && (rd_entry.side == side_r);

  assign sts.out_free   = !out_valid_r || out_ready;
  assign sts.wrap       = is_clear && (tag_r == {TAG_W{1'b1}});
  assign sts.sweep_last = (sweep_cnt_r == IDX_MASK);

  always_comb begin
    wr_entry       = '0;
    wr_entry.key   = key_r;
    wr_entry.side  = side_r;
    wr_entry.score = score_r;
    wr_entry.tag   = tag_r;
    if (cmd.sweep_wr) begin
      wr_entry = '0;
    end
  end

  assign ram_we    = cmd.sweep_wr || (cmd.exec && is_store);
  assign ram_waddr = cmd.sweep_wr ? sweep_cnt_r : idx_r;

  ghc_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (SLOTS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_entry),
    .re    (cmd.accept),
    .raddr (rd_idx),
    .rdata (rd_entry)
  );

  always_comb begin
    tag_nxt  = tag_r;
    use_nxt  = use_r;
    hits_nxt = hits_r;
    miss_nxt = miss_r;
    case (op_r)
      OP_PROBE: begin
        if (hit) begin
          hits_nxt = (hits_r == {CNT_W{1'b1}}) ? hits_r : hits_r + 1'b1;
        end else begin
          miss_nxt = (miss_r == {CNT_W{1'b1}}) ? miss_r : miss_r + 1'b1;
        end
      end
      OP_STORE: begin
        if (!tag_match) begin
          use_nxt = use_r + 1'b1;
        end
      end
      OP_CLEAR: begin
        tag_nxt  = sts.wrap ? TAG_W'(1) : tag_r + 1'b1;
        use_nxt  = '0;
        hits_nxt = '0;
        miss_nxt = '0;
      end
      default: begin
        tag_nxt = tag_r;
      end
    endcase
  end

  assign sweep_cnt_nxt = sts.sweep_last ? '0 : sweep_cnt_r + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r    <= in_op;
      key_r   <= in_key;
      side_r  <= in_side_to_move;
      score_r <= in_store_score;
      idx_r   <= rd_idx;
    end
    if (cmd.exec) begin
      found_r  <= hit;
      pscore_r <= hit ? rd_entry.score : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_cnt_r <= '0;
      tag_r       <= TAG_W'(1);
      use_r       <= '0;
      hits_r      <= '0;
      miss_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.sweep_wr) begin
        sweep_cnt_r <= sweep_cnt_nxt;
      end
      if (cmd.exec) begin
        tag_r       <= tag_nxt;
        use_r       <= use_nxt;
        hits_r      <= hits_nxt;
        miss_r      <= miss_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_hit            = found_r;
  assign out_probe_score    = pscore_r;
  assign out_entries_in_use = use_r;
  assign out_hit_count      = hits_r;
  assign out_miss_count     = miss_r;

  a_tag_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    tag_r != '0)
    else $error("generation tag is zero");

  a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && is_clear |=> (out_hit_count == '0) && (out_miss_count == '0)
      && (out_entries_in_use == '0))
    else $error("clear left nonzero counts");

  a_nonprobe_miss: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && !is_probe |=> !out_hit && (out_probe_score == '0))
    else $error("non-probe result reports a hit");

  a_sweep_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sweep_wr |-> !cmd.exec && !cmd.accept)
    else $error("sweep overlaps an operation");

  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid)
    else $error("executed operation produced no result");

endmodule
`default_nettype wire

// ===== rtl/generation_tagged_hash_cache.sv =====
// Each accepted transfer is registered with its table read; the result is registered at out_
// once the previous result is taken. A new operation is accepted only after the last one has
// executed; the registered table read is followed by any write-back on the single write port.
// Reset: a tag sweep that zeroes every slot of the rounded-up table depth (4096 by default)
// runs with in_ready low; a clear that wraps the generation tag runs the same sweep afterward.
`default_nettype none
module generation_tagged_hash_cache #(
  parameter int TABLE_DEPTH = 4096
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [1:0]                         in_op,
  input  wire logic [ghc_pkg::KEY_W-1:0]          in_key,
  input  wire logic                               in_side_to_move,
  input  wire logic signed [ghc_pkg::SCORE_W-1:0] in_store_score,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    out_hit,
  output logic signed [ghc_pkg::SCORE_W-1:0]      out_probe_score,
  output logic [ghc_pkg::USE_W-1:0]               out_entries_in_use,
  output logic [ghc_pkg::CNT_W-1:0]               out_hit_count,
  output logic [ghc_pkg::CNT_W-1:0]               out_miss_count
);
  import ghc_pkg::*;

  localparam int SLOTS = 1 << $clog2(TABLE_DEPTH);
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  cmd_t cmd;
  sts_t sts;

  ghc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ghc_dp #(
    .SLOTS (SLOTS),
    .AW    (AW)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_op              (in_op),
    .in_key             (in_key),
    .in_side_to_move    (in_side_to_move),
    .in_store_score     (in_store_score),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_hit            (out_hit),
    .out_probe_score    (out_probe_score),
    .out_entries_in_use (out_entries_in_use),
    .out_hit_count      (out_hit_count),
    .out_miss_count     (out_miss_count)
  );

endmodule
`default_nettype wire
